[src/deque_with_search_update_core_defines.svh]
// Assertion macros used by the deque RTL.
// Included by files that check their own control logic; needs no package.
`ifndef DEQUE_WITH_SEARCH_UPDATE_CORE_DEFINES_SVH
`define DEQUE_WITH_SEARCH_UPDATE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, disabled during reset.
`define DQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, disabled during reset.
`define DQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/dqsu_pkg.sv]
// Shared types and codes for the deque core.
// No dependencies; used by the cell, the chain and the top level.
`default_nettype none

package dqsu_pkg;

    localparam int VAL_W = 32;

    // command codes
    localparam logic [2:0] CMD_PUSH_TAIL = 3'd0;
    localparam logic [2:0] CMD_PUSH_HEAD = 3'd1;
    localparam logic [2:0] CMD_POP_HEAD  = 3'd2;
    localparam logic [2:0] CMD_REPLACE   = 3'd3;
    localparam logic [2:0] CMD_CLEAR     = 3'd4;

    // status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_EMPTY    = 2'd1;
    localparam logic [1:0] STS_FULL     = 2'd2;
    localparam logic [1:0] STS_NOTFOUND = 2'd3;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic shift_head;  // push at head: every cell takes its left neighbor
        logic shift_pop;   // pop head: every cell takes its right neighbor
        logic wr_tail;     // push at tail: the cell at index count loads
        logic inject;      // start a search token at the head cell
        logic step;        // move the search token one cell toward the tail
        logic search;      // search is running: the token cell compares
    } cell_ctrl_t;

endpackage

`default_nettype wire

[src/dqsu_cell.sv]
// One deque cell: holds one entry and a search token bit.
// Depends on dqsu_pkg for the control struct and value width.
`default_nettype none

module dqsu_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  dqsu_pkg::cell_ctrl_t          ctrl,
    input  wire  [CNT_W-1:0]              count,
    input  wire  [dqsu_pkg::VAL_W-1:0]    push_value,
    input  wire  [dqsu_pkg::VAL_W-1:0]    key,
    input  wire  [dqsu_pkg::VAL_W-1:0]    new_value,
    input  wire  [dqsu_pkg::VAL_W-1:0]    left_data,
    input  wire  [dqsu_pkg::VAL_W-1:0]    right_data,
    input  wire                           left_tok,
    output logic [dqsu_pkg::VAL_W-1:0]    data_q,
    output logic                          tok_q,
    output logic                          hit
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [dqsu_pkg::VAL_W-1:0] data_reg, data_next;
    logic                       tok_reg, tok_next;

    // a token only lives while a search runs, so the token alone marks the compare
    assign hit = tok_reg & (data_reg == key);

    always_comb begin
        data_next = data_reg;
        if (ctrl.shift_head) begin
            data_next = left_data;
        end else if (ctrl.shift_pop) begin
            data_next = right_data;
        end else if (ctrl.wr_tail && (count == IDX_C)) begin
            data_next = push_value;
        end else if (ctrl.search && hit) begin
            data_next = new_value;
        end
    end

    // inject loads the head cell (its left token is the inject line), clears the rest
    assign tok_next = (ctrl.inject | ctrl.step) & left_tok;

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign data_q = data_reg;
    assign tok_q  = tok_reg;

endmodule

`default_nettype wire

[src/dqsu_chain.sv]
// Row of deque cells, head at cell 0, with neighbor links and a hit reduction.
// Depends on dqsu_pkg and dqsu_cell.
`default_nettype none

module dqsu_chain #(
    parameter int DEPTH = 16,
    parameter int CNT_W = 5
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  dqsu_pkg::cell_ctrl_t          ctrl,
    input  wire  [CNT_W-1:0]              count,
    input  wire  [dqsu_pkg::VAL_W-1:0]    push_value,
    input  wire  [dqsu_pkg::VAL_W-1:0]    key,
    input  wire  [dqsu_pkg::VAL_W-1:0]    new_value,
    output logic [dqsu_pkg::VAL_W-1:0]    head_data,
    output logic                          hit_any
);

    logic [dqsu_pkg::VAL_W-1:0] data_w [DEPTH];
    logic [dqsu_pkg::VAL_W-1:0] left_w [DEPTH];
    logic [dqsu_pkg::VAL_W-1:0] right_w [DEPTH];
    logic [DEPTH-1:0]           tok_w;
    logic [DEPTH-1:0]           ltok_w;
    logic [DEPTH-1:0]           hit_w;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_first
                assign left_w[gi] = push_value;
                assign ltok_w[gi] = ctrl.inject;
            end else begin : g_mid
                assign left_w[gi] = data_w[gi-1];
                assign ltok_w[gi] = tok_w[gi-1];
            end
            if (gi == DEPTH-1) begin : g_last
                assign right_w[gi] = data_w[gi];
            end else begin : g_notlast
                assign right_w[gi] = data_w[gi+1];
            end

            dqsu_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .count      (count),
                .push_value (push_value),
                .key        (key),
                .new_value  (new_value),
                .left_data  (left_w[gi]),
                .right_data (right_w[gi]),
                .left_tok   (ltok_w[gi]),
                .data_q     (data_w[gi]),
                .tok_q      (tok_w[gi]),
                .hit        (hit_w[gi])
            );
        end
    endgenerate

    assign head_data = data_w[0];
    assign hit_any   = |hit_w;

endmodule

`default_nettype wire

[src/deque_with_search_update_core.sv]
// Bounded deque of unsigned 32-bit values with push tail/head, pop, replace, clear.
// Depends on dqsu_pkg, dqsu_chain (dqsu_cell) and the assertion macro header.
//
// Usage:
//   s_ channel carries one command per transaction: s_tuser holds the command
//   code, s_tdata the push value (or search key) and the replacement value.
//   m_ channel returns one result per command: status, popped head value
//   (zero unless a pop succeeded) and the entry count after the command.
//   Entries live in a row of DEPTH cells with the head at cell 0; push at
//   head and pop shift the whole row by one cell.
//   Results: push, pop, clear and unused codes give their result in the cycle
//   after acceptance. A replace walks a search token from the head, one cell
//   per cycle, and its result is loaded when the token finds the key or
//   reaches the last entry.
//   Throughput: one command per cycle while the result register drains; the
//   token walk holds off new commands until the replace result is loaded.
//   Stall: the result register holds while m_tready is low; a new command is
//   taken only in the cycle that result leaves or once it is empty.
//   Reset (aresetn low, synchronous): count, state and tokens clear, no result
//   pending; the cell contents stay undefined until pushed.
`default_nettype none

`include "deque_with_search_update_core_defines.svh"

module deque_with_search_update_core #(
    parameter int DEPTH = 16,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int OUT_W = ((34 + CNT_W + 7) / 8) * 8
) (
    input  wire              aclk,
    input  wire              aresetn,
    // input: s_tdata = {new_value[63:32], value[31:0]}
    input  wire              s_tvalid,
    output logic             s_tready,
    input  wire  [63:0]      s_tdata,
    // s_tuser = cmd[2:0]
    input  wire  [2:0]       s_tuser,
    // output: m_tdata = {zero pad, entry_count, removed_value[33:2], status[1:0]}
    output logic             m_tvalid,
    input  wire              m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    localparam logic       ST_IDLE   = 1'b0;
    localparam logic       ST_SEARCH = 1'b1;
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic                       state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           k_reg, k_next;
    logic [dqsu_pkg::VAL_W-1:0] key_reg, key_next;
    logic [dqsu_pkg::VAL_W-1:0] nval_reg, nval_next;
    logic                       mvld_reg, mvld_next;
    logic [1:0]                 msts_reg, msts_next;
    logic [dqsu_pkg::VAL_W-1:0] mrem_reg, mrem_next;
    logic [CNT_W-1:0]           mcnt_reg, mcnt_next;

    dqsu_pkg::cell_ctrl_t       ctrl;
    logic [dqsu_pkg::VAL_W-1:0] head_data;
    logic                       hit_any;
    logic                       accept;
    logic                       is_full, is_empty, last_cell;
    logic                       in_search, replace_go;
    logic [2:0]                 cmd;
    logic [dqsu_pkg::VAL_W-1:0] in_value, in_nval;

    assign cmd      = s_tuser;
    assign in_value = s_tdata[31:0];
    assign in_nval  = s_tdata[63:32];

    // take a command only when idle and the result slot is free or freeing
    assign s_tready = (state_reg == ST_IDLE) && (!mvld_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign is_full   = (count_reg == CNT_FULL);
    assign is_empty  = (count_reg == '0);
    assign last_cell = (k_reg == (count_reg - CNT_ONE));

    assign in_search  = (state_reg == ST_SEARCH);
    assign replace_go = accept && (cmd == dqsu_pkg::CMD_REPLACE) && !is_empty;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        k_next     = k_reg;
        key_next   = key_reg;
        nval_next  = nval_reg;
        mvld_next  = mvld_reg && !m_tready;
        msts_next  = msts_reg;
        mrem_next  = mrem_reg;
        mcnt_next  = mcnt_reg;
        ctrl       = '0;

        if (accept) begin
            mvld_next = 1'b1;
            msts_next = dqsu_pkg::STS_OK;
            mrem_next = '0;
            case (cmd)
                dqsu_pkg::CMD_PUSH_TAIL: begin
                    if (is_full) begin
                        msts_next = dqsu_pkg::STS_FULL;
                    end else begin
                        ctrl.wr_tail = 1'b1;
                        count_next   = count_reg + CNT_ONE;
                    end
                end
                dqsu_pkg::CMD_PUSH_HEAD: begin
                    if (is_full) begin
                        msts_next = dqsu_pkg::STS_FULL;
                    end else begin
                        ctrl.shift_head = 1'b1;
                        count_next      = count_reg + CNT_ONE;
                    end
                end
                dqsu_pkg::CMD_POP_HEAD: begin
                    if (is_empty) begin
                        msts_next = dqsu_pkg::STS_EMPTY;
                    end else begin
                        ctrl.shift_pop = 1'b1;
                        mrem_next      = head_data;
                        count_next     = count_reg - CNT_ONE;
                    end
                end
                dqsu_pkg::CMD_REPLACE: begin
                    if (is_empty) begin
                        msts_next = dqsu_pkg::STS_EMPTY;
                    end else begin
                        // hold the result until the token walk ends
                        mvld_next   = 1'b0;
                        ctrl.inject = 1'b1;
                        state_next  = ST_SEARCH;
                        k_next      = '0;
                        key_next    = in_value;
                        nval_next   = in_nval;
                    end
                end
                dqsu_pkg::CMD_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                end
            endcase
            mcnt_next = count_next;
        end else if (state_reg == ST_SEARCH) begin
            ctrl.search = 1'b1;
            if (hit_any || last_cell) begin
                // the hit cell writes new_value in this same cycle
                state_next = ST_IDLE;
                mvld_next  = 1'b1;
                msts_next  = hit_any ? dqsu_pkg::STS_OK : dqsu_pkg::STS_NOTFOUND;
                mrem_next  = '0;
                mcnt_next  = count_reg;
            end else begin
                ctrl.step = 1'b1;
                k_next    = k_reg + CNT_ONE;
            end
        end
    end

    dqsu_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .count      (count_reg),
        .push_value (in_value),
        .key        (key_reg),
        .new_value  (nval_reg),
        .head_data  (head_data),
        .hit_any    (hit_any)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            mvld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            mvld_reg  <= mvld_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg    <= k_next;
        key_reg  <= key_next;
        nval_reg <= nval_next;
        msts_reg <= msts_next;
        mrem_reg <= mrem_next;
        mcnt_reg <= mcnt_next;
    end

    assign m_tvalid = mvld_reg;
    assign m_tdata  = {{(OUT_W - 34 - CNT_W){1'b0}}, mcnt_reg, mrem_reg, msts_reg};

    `DQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_FULL, "entry count above depth")
    `DQ_ASSERT_IMP(a_search_blocks, in_search, !s_tready && !mvld_reg, "search overlaps")
    `DQ_ASSERT_IMP(a_walk_bound, in_search, k_reg < count_reg, "token walked past tail")
    `DQ_ASSERT_NXT(a_replace_walks, replace_go, in_search && !mvld_reg, "search not started")

endmodule

`default_nettype wire
